[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on the local clk_i, skipped while rst_ni is low.
`define MLTE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check on an explicitly named clock and active-low reset.
`define MLTE_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

[hw/rtl/mlte_pkg.sv]
`default_nettype none

package mlte_pkg;

  typedef enum logic [2:0] {
    CMD_CREATE = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_RESIZE = 3'd4,
    CMD_READ   = 3'd5
  } cmd_e;

  typedef enum logic [3:0] {
    STAT_OK           = 4'd0,
    STAT_BAD_SLOT     = 4'd1,
    STAT_BAD_SIZE     = 4'd2,
    STAT_EXISTS       = 4'd3,
    STAT_NO_LIST      = 4'd4,
    STAT_FULL         = 4'd5,
    STAT_EMPTY        = 4'd6,
    STAT_NOT_FOUND    = 4'd7,
    STAT_BAD_NEW_SIZE = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEARCH,
    S_SHIFT,
    S_READ
  } state_e;

  // What a decoded command needs from the sequencer.
  typedef enum logic [1:0] {
    DEC_DROP,
    DEC_SINGLE,
    DEC_SEARCH,
    DEC_READ
  } dec_e;

  typedef struct packed {
    logic [2:0]         command;
    logic [3:0]         slot;
    logic signed [7:0]  amount;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [3:0]         status;
    logic signed [31:0] data_value;
    logic               last;
  } res_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan;
    logic hit_take;
    logic shift;
    logic del_done;
    logic not_found;
    logic emit_data;
  } dp_cmd_t;

  typedef struct packed {
    dec_e kind;
    logic scan_end;
    logic rd_hit;
    logic rd_last;
  } dp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/mlte_dp.sv]
`default_nettype none

`include "assert_macros.svh"

module mlte_dp #(
  parameter int unsigned SLOTS    = 10,
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mlte_pkg::req_t     req_i,
  input  wire mlte_pkg::dp_cmd_t  cmd_i,
  output mlte_pkg::dp_stat_t      stat_o,
  output logic                    res_valid_o,
  output mlte_pkg::res_t          res_o
);

  localparam int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned DEPTH = SLOTS * CAPACITY;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic signed [9:0] CAP_S = 10'(CAPACITY);

  mlte_pkg::req_t req_q;

  logic          present_q [SLOTS];
  logic [CW-1:0] cap_q     [SLOTS];
  logic [CW-1:0] fill_q    [SLOTS];
  logic          present_d [SLOTS];
  logic [CW-1:0] cap_d     [SLOTS];
  logic [CW-1:0] fill_d    [SLOTS];

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q;

  logic [CW-1:0] idx_q, idx_d, rd_idx_q, rd_idx_d;
  logic          rd_vld_q, rd_vld_d;

  logic           res_valid_q, res_valid_d;
  mlte_pkg::res_t res_q, res_d;

  logic [SW-1:0] sidx;
  logic          slot_ok, cur_present;
  logic [CW-1:0] cur_cap, cur_fill;
  logic [AW-1:0] base, rd_addr, wr_addr;
  logic          wr_en;
  logic [31:0]   wr_data;

  logic signed [9:0] amt_x, cap_x, fill_x, ncap;
  mlte_pkg::dec_e    kind;
  mlte_pkg::status_e dstat;
  logic              issue, rd_hit, rd_last;

  assign sidx        = SW'(req_q.slot - 4'd1);
  assign slot_ok     = (req_q.slot != 4'd0) && (req_q.slot <= 4'(SLOTS));
  assign cur_present = slot_ok ? present_q[sidx] : 1'b0;
  assign cur_cap     = slot_ok ? cap_q[sidx] : '0;
  assign cur_fill    = slot_ok ? fill_q[sidx] : '0;

  assign base    = AW'(sidx) * AW'(CAPACITY);
  assign rd_addr = base + AW'(idx_q);

  assign amt_x  = {{2{req_q.amount[7]}}, req_q.amount};
  assign cap_x  = $signed({{(10 - CW){1'b0}}, cur_cap});
  assign fill_x = $signed({{(10 - CW){1'b0}}, cur_fill});
  assign ncap   = cap_x + amt_x;

  // Decide the outcome of the held command from the slot tables.
  always_comb begin
    kind  = mlte_pkg::DEC_SINGLE;
    dstat = mlte_pkg::STAT_OK;
    if (req_q.command > 3'(mlte_pkg::CMD_READ)) begin
      kind = mlte_pkg::DEC_DROP;
    end else if (!slot_ok) begin
      dstat = mlte_pkg::STAT_BAD_SLOT;
    end else if (req_q.command == 3'(mlte_pkg::CMD_CREATE)) begin
      if (amt_x <= 10'sd0) begin
        dstat = mlte_pkg::STAT_BAD_SIZE;
      end else if (cur_present) begin
        dstat = mlte_pkg::STAT_EXISTS;
      end else if (amt_x > CAP_S) begin
        dstat = mlte_pkg::STAT_BAD_SIZE;
      end
    end else if (!cur_present) begin
      dstat = mlte_pkg::STAT_NO_LIST;
    end else begin
      case (mlte_pkg::cmd_e'(req_q.command))
        mlte_pkg::CMD_APPEND: begin
          if (cur_fill >= cur_cap) dstat = mlte_pkg::STAT_FULL;
        end
        mlte_pkg::CMD_REMOVE: begin
          if (cur_fill == '0) dstat = mlte_pkg::STAT_EMPTY;
        end
        mlte_pkg::CMD_DELETE: begin
          if (cur_fill == '0) dstat = mlte_pkg::STAT_NOT_FOUND;
          else kind = mlte_pkg::DEC_SEARCH;
        end
        mlte_pkg::CMD_RESIZE: begin
          if (ncap < 10'sd1 || ncap > CAP_S) dstat = mlte_pkg::STAT_BAD_NEW_SIZE;
        end
        mlte_pkg::CMD_READ: begin
          if (cur_fill == '0) dstat = mlte_pkg::STAT_EMPTY;
          else kind = mlte_pkg::DEC_READ;
        end
        default: begin
          kind = mlte_pkg::DEC_DROP;
        end
      endcase
    end
  end

  assign issue   = cmd_i.scan && (idx_q < cur_fill);
  assign rd_hit  = rd_vld_q && (rdata_q == req_q.value);
  assign rd_last = rd_vld_q && ((rd_idx_q + CW'(1)) == cur_fill);

  // Scan pointer and read pipeline.
  always_comb begin
    idx_d    = idx_q;
    rd_idx_d = rd_idx_q;
    rd_vld_d = 1'b0;
    if (cmd_i.exec) begin
      idx_d = '0;
    end else if (cmd_i.hit_take) begin
      idx_d = rd_idx_q + CW'(1);
    end else if (issue) begin
      idx_d    = idx_q + CW'(1);
      rd_idx_d = idx_q;
      rd_vld_d = 1'b1;
    end
  end

  // Table updates and element store write port.
  always_comb begin
    present_d = present_q;
    cap_d     = cap_q;
    fill_d    = fill_q;
    wr_en     = 1'b0;
    wr_addr   = base + AW'(cur_fill);
    wr_data   = req_q.value;
    if (cmd_i.exec && kind == mlte_pkg::DEC_SINGLE && dstat == mlte_pkg::STAT_OK) begin
      case (mlte_pkg::cmd_e'(req_q.command))
        mlte_pkg::CMD_CREATE: begin
          present_d[sidx] = 1'b1;
          cap_d[sidx]     = req_q.amount[CW-1:0];
          fill_d[sidx]    = '0;
        end
        mlte_pkg::CMD_APPEND: begin
          wr_en        = 1'b1;
          fill_d[sidx] = cur_fill + CW'(1);
        end
        mlte_pkg::CMD_REMOVE: begin
          fill_d[sidx] = cur_fill - CW'(1);
        end
        mlte_pkg::CMD_RESIZE: begin
          cap_d[sidx] = ncap[CW-1:0];
          if (fill_x > ncap) fill_d[sidx] = ncap[CW-1:0];
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.shift && rd_vld_q) begin
      // Move each later entry down by one.
      wr_en   = 1'b1;
      wr_addr = base + AW'(rd_idx_q) - AW'(1);
      wr_data = rdata_q;
    end
    if (cmd_i.del_done) begin
      fill_d[sidx] = cur_fill - CW'(1);
    end
  end

  // Result register: every result shows for exactly one cycle.
  always_comb begin
    res_valid_d = 1'b0;
    res_d       = '{status: 4'(mlte_pkg::STAT_OK), data_value: 32'sd0, last: 1'b1};
    if (cmd_i.exec && kind == mlte_pkg::DEC_SINGLE) begin
      res_valid_d  = 1'b1;
      res_d.status = 4'(dstat);
    end else if (cmd_i.not_found) begin
      res_valid_d  = 1'b1;
      res_d.status = 4'(mlte_pkg::STAT_NOT_FOUND);
    end else if (cmd_i.del_done) begin
      res_valid_d = 1'b1;
    end else if (cmd_i.emit_data && rd_vld_q) begin
      res_valid_d      = 1'b1;
      res_d.data_value = rdata_q;
      res_d.last       = rd_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(SLOTS); i++) begin
        present_q[i] <= 1'b0;
        cap_q[i]     <= '0;
        fill_q[i]    <= '0;
      end
      idx_q       <= '0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      present_q   <= present_d;
      cap_q       <= cap_d;
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      rd_idx_q    <= rd_idx_d;
      rd_vld_q    <= rd_vld_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rdata_q <= mem_q[rd_addr];
  end

  assign stat_o.kind     = kind;
  assign stat_o.scan_end = (idx_q == cur_fill);
  assign stat_o.rd_hit   = rd_hit;
  assign stat_o.rd_last  = rd_last;

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `MLTE_ASSERT(a_rd_in_fill, rd_vld_q |-> (rd_idx_q < cur_fill), "read beyond fill")
  `MLTE_ASSERT(a_fill_le_cap, cur_present |-> (cur_fill <= cur_cap), "fill above capacity")

endmodule

`default_nettype wire

[hw/rtl/mlte_ctrl.sv]
`default_nettype none

`include "assert_macros.svh"

module mlte_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire mlte_pkg::dp_stat_t stat_i,
  output logic                    busy_o,
  output mlte_pkg::dp_cmd_t       cmd_o
);

  mlte_pkg::state_e state_q, state_d;
  logic             hit_in_search;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mlte_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      mlte_pkg::S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = mlte_pkg::S_DECODE;
        end
      end
      mlte_pkg::S_DECODE: begin
        cmd_o.exec = 1'b1;
        case (stat_i.kind)
          mlte_pkg::DEC_SEARCH: state_d = mlte_pkg::S_SEARCH;
          mlte_pkg::DEC_READ:   state_d = mlte_pkg::S_READ;
          default:              state_d = mlte_pkg::S_IDLE;
        endcase
      end
      mlte_pkg::S_SEARCH: begin
        if (stat_i.rd_hit) begin
          cmd_o.hit_take = 1'b1;
          state_d        = mlte_pkg::S_SHIFT;
        end else if (stat_i.rd_last) begin
          cmd_o.not_found = 1'b1;
          state_d         = mlte_pkg::S_IDLE;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      mlte_pkg::S_SHIFT: begin
        cmd_o.scan  = 1'b1;
        cmd_o.shift = 1'b1;
        if (stat_i.scan_end) begin
          cmd_o.del_done = 1'b1;
          state_d        = mlte_pkg::S_IDLE;
        end
      end
      mlte_pkg::S_READ: begin
        cmd_o.scan      = 1'b1;
        cmd_o.emit_data = 1'b1;
        if (stat_i.rd_last) state_d = mlte_pkg::S_IDLE;
      end
      default: begin
        state_d = mlte_pkg::S_IDLE;
      end
    endcase
  end

  assign hit_in_search = (state_q == mlte_pkg::S_SEARCH) && stat_i.rd_hit;

  `MLTE_ASSERT(a_hit_to_shift, hit_in_search |=> (state_q == mlte_pkg::S_SHIFT), "no shift after hit")

endmodule

`default_nettype wire

[hw/rtl/multi_list_table_engine_unit.sv]
// Channel    | Direction | Handshake                   | Payload
// command    | in        | start high while busy low   | req_i (command, slot, amount, value)
// result     | out       | res_valid_o, one-cycle pulse | res_o (status, data_value, last)
//
// A command is taken at the edge where start is high and busy is low; busy rises the
// next cycle. Single-result commands are answered from the result register after decode.
// Read-all of n entries streams n back-to-back results. Delete searches, then shifts on
// a match; a miss ends after the search. The one-read, one-write element memory sets
// the pace: one entry a cycle. Reset clears the slot tables and control state, not the
// element memory; results show for one cycle and the receiver cannot stall.
`default_nettype none

`include "assert_macros.svh"

module multi_list_table_engine_unit #(
  parameter int unsigned SLOTS    = 10,
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire mlte_pkg::req_t req_i,
  output logic                res_valid_o,
  output mlte_pkg::res_t      res_o
);

  // Command and status buses between sequencer and datapath.
  mlte_pkg::dp_cmd_t  dp_cmd;
  mlte_pkg::dp_stat_t dp_stat;

  // Sequence each transaction: decode, then search, shift or stream.
  mlte_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (dp_stat),
    .busy_o  (busy),
    .cmd_o   (dp_cmd)
  );

  // Hold the slot tables, the element memory and the result register.
  mlte_dp #(
    .SLOTS    (SLOTS),
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // An accepted transaction always raises busy on the next cycle.
  `MLTE_ASSERT_CLK(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy, "accept without busy")
  // A read-all stream has no gaps until its last item.
  `MLTE_ASSERT(a_stream_gapless, (res_valid_o && !res_o.last) |=> res_valid_o, "gap in stream")

endmodule

`default_nettype wire

[bench/multi_list_table_engine_unit_test.sv]
`timescale 1ns / 100ps

module multi_list_table_engine_unit_test;

  localparam int SLOT_COUNT    = 10;
  localparam int LIST_CAP      = 64;
  localparam int RANDOM_TARGET = 500;
  // Worst quiet stretch: a long sender gap plus a full-depth delete (search and shift).
  localparam int QUIET_LIMIT   = 2000;
  localparam int END_SETTLE    = 2 * LIST_CAP + 16;
  localparam int STATUS_CODES  = 9;
  localparam int POOL_SIZE     = 6;

  // Command codes the block must ignore without answering.
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  typedef struct {
    mlte_pkg::req_t req;
    bit             drain_first;  // hold this transaction until every awaited result is in
  } pending_cmd_t;

  typedef struct {
    mlte_pkg::res_t res;
    int             cmd_no;
  } awaited_t;

  logic           clk_i  = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start  = 1'b0;
  mlte_pkg::req_t req_i  = '0;
  logic           busy;
  logic           res_valid_o;
  mlte_pkg::res_t res_o;

  // Stimulus waiting to be driven, and results predicted but not yet seen.
  pending_cmd_t command_queue[$];
  awaited_t     awaited_results[$];

  // Shadow copy of the slot table.
  bit          list_live [SLOT_COUNT];
  int          list_cap  [SLOT_COUNT];
  int          list_fill [SLOT_COUNT];
  logic [31:0] list_mem  [SLOT_COUNT][LIST_CAP];

  logic [31:0] value_pool [POOL_SIZE];

  int  error_count;
  int  counted_cmds;
  int  cmds_total;
  int  cmds_accepted;
  int  results_seen;
  int  spare_cmds;
  int  reads_streamed;
  int  longest_read;
  int  quiet_cycles;
  int  status_tally [STATUS_CODES];
  int  gap_left;
  int  burst_left;
  bit  drained = 1'b1;

  multi_list_table_engine_unit #(
    .SLOTS    (SLOT_COUNT),
    .CAPACITY (LIST_CAP)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Print one line per mismatch and count it.
  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  function automatic void push_outcome(mlte_pkg::status_e st, logic [31:0] data, bit is_last);
    awaited_t a;
    a.res.status     = st;
    a.res.data_value = data;
    a.res.last       = is_last;
    a.cmd_no         = cmds_accepted;
    awaited_results.push_back(a);
    status_tally[st]++;
  endfunction

  // Advance the shadow table by one accepted transaction and queue what it must answer.
  task automatic apply_list_command(input mlte_pkg::req_t c);
    int s;
    int amt;
    int ncap;
    int hit;
    amt = c.amount;
    // Spare codes: no answer, no state change.
    if (c.command > mlte_pkg::CMD_READ) begin
      spare_cmds++;
      return;
    end
    if (c.slot < 1 || c.slot > SLOT_COUNT) begin
      push_outcome(mlte_pkg::STAT_BAD_SLOT, '0, 1'b1);
      return;
    end
    s = c.slot - 1;
    // Create checks run in a fixed order: size sign, existing list, then the upper bound.
    if (c.command == mlte_pkg::CMD_CREATE) begin
      if (amt <= 0) begin
        push_outcome(mlte_pkg::STAT_BAD_SIZE, '0, 1'b1);
      end else if (list_live[s]) begin
        push_outcome(mlte_pkg::STAT_EXISTS, '0, 1'b1);
      end else if (amt > LIST_CAP) begin
        push_outcome(mlte_pkg::STAT_BAD_SIZE, '0, 1'b1);
      end else begin
        list_live[s] = 1'b1;
        list_cap[s]  = amt;
        list_fill[s] = 0;
        push_outcome(mlte_pkg::STAT_OK, '0, 1'b1);
      end
      return;
    end
    if (!list_live[s]) begin
      push_outcome(mlte_pkg::STAT_NO_LIST, '0, 1'b1);
      return;
    end
    case (c.command)
      mlte_pkg::CMD_APPEND: begin
        if (list_fill[s] >= list_cap[s]) begin
          push_outcome(mlte_pkg::STAT_FULL, '0, 1'b1);
        end else begin
          list_mem[s][list_fill[s]] = c.value;
          list_fill[s]++;
          push_outcome(mlte_pkg::STAT_OK, '0, 1'b1);
        end
      end
      mlte_pkg::CMD_REMOVE: begin
        if (list_fill[s] == 0) begin
          push_outcome(mlte_pkg::STAT_EMPTY, '0, 1'b1);
        end else begin
          list_fill[s]--;
          push_outcome(mlte_pkg::STAT_OK, '0, 1'b1);
        end
      end
      mlte_pkg::CMD_DELETE: begin
        // Drop the first match and close the hole.
        hit = -1;
        for (int i = 0; i < list_fill[s]; i++)
          if (hit < 0 && list_mem[s][i] == c.value) hit = i;
        if (hit < 0) begin
          push_outcome(mlte_pkg::STAT_NOT_FOUND, '0, 1'b1);
        end else begin
          for (int i = hit; i + 1 < list_fill[s]; i++) list_mem[s][i] = list_mem[s][i + 1];
          list_fill[s]--;
          push_outcome(mlte_pkg::STAT_OK, '0, 1'b1);
        end
      end
      mlte_pkg::CMD_RESIZE: begin
        ncap = list_cap[s] + amt;
        if (ncap < 1 || ncap > LIST_CAP) begin
          push_outcome(mlte_pkg::STAT_BAD_NEW_SIZE, '0, 1'b1);
        end else begin
          // Shrinking below the fill count truncates the list.
          list_cap[s] = ncap;
          if (list_fill[s] > ncap) list_fill[s] = ncap;
          push_outcome(mlte_pkg::STAT_OK, '0, 1'b1);
        end
      end
      mlte_pkg::CMD_READ: begin
        if (list_fill[s] == 0) begin
          push_outcome(mlte_pkg::STAT_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < list_fill[s]; i++)
            push_outcome(mlte_pkg::STAT_OK, list_mem[s][i], i == list_fill[s] - 1);
          reads_streamed++;
          if (list_fill[s] > longest_read) longest_read = list_fill[s];
        end
      end
      default: ;
    endcase
  endtask

  // Compare one result with the oldest expectation, field by field.
  task automatic check_result(input mlte_pkg::res_t got);
    awaited_t want;
    if (awaited_results.size() == 0) begin
      flag_mismatch($sformatf("result with nothing awaited: status %0d data %0h last %0b",
                              got.status, got.data_value, got.last));
    end else begin
      want = awaited_results.pop_front();
      if (got.status !== want.res.status)
        flag_mismatch($sformatf("transaction %0d status %0d, want %0d",
                                want.cmd_no, got.status, want.res.status));
      if (got.data_value !== want.res.data_value)
        flag_mismatch($sformatf("transaction %0d data %0h, want %0h",
                                want.cmd_no, got.data_value, want.res.data_value));
      if (got.last !== want.res.last)
        flag_mismatch($sformatf("transaction %0d last %0b, want %0b",
                                want.cmd_no, got.last, want.res.last));
    end
  endtask

  function automatic void add_cmd(logic [2:0] op, int slot, int amount, logic [31:0] value,
                                  bit drain_first);
    pending_cmd_t p;
    p.req.command  = op;
    p.req.slot     = slot[3:0];
    p.req.amount   = amount[7:0];
    p.req.value    = value;
    p.drain_first  = drain_first;
    command_queue.push_back(p);
    // Spare codes do nothing in the block, so they do not count toward the item budget.
    if (op <= mlte_pkg::CMD_READ) counted_cmds++;
  endfunction

  // Favor a small pool so deletes hit often; mix in fully random words.
  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 9) < 6) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom();
  endfunction

  task automatic build_stimulus();
    int  s;
    int  size;
    int  roll;
    int  directed;
    bit  first_seq;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h7FFF_FFFF;
    value_pool[4] = $urandom();
    value_pool[5] = $urandom();

    // Directed: slot bounds, create ordering, every status, spare codes.
    add_cmd(mlte_pkg::CMD_APPEND, 0, 0, 32'h1, 1'b0);
    add_cmd(mlte_pkg::CMD_READ, 15, 0, 32'h0, 1'b0);
    add_cmd(mlte_pkg::CMD_CREATE, SLOT_COUNT + 1, 4, 32'h0, 1'b0);
    add_cmd(mlte_pkg::CMD_APPEND, 1, 0, 32'h5, 1'b0);
    add_cmd(mlte_pkg::CMD_CREATE, 1, 0, 32'h0, 1'b0);
    add_cmd(mlte_pkg::CMD_CREATE, 1, -128, 32'h0, 1'b0);
    add_cmd(mlte_pkg::CMD_CREATE, 1, LIST_CAP + 1, 32'h0, 1'b0);
    add_cmd(mlte_pkg::CMD_CREATE, 1, 127, 32'h0, 1'b0);
    add_cmd(mlte_pkg::CMD_CREATE, 1, 2, 32'h0, 1'b0);
    add_cmd(mlte_pkg::CMD_CREATE, 1, -1, 32'h0, 1'b0);
    add_cmd(mlte_pkg::CMD_CREATE, 1, 100, 32'h0, 1'b0);
    add_cmd(mlte_pkg::CMD_REMOVE, 1, 0, 32'h0, 1'b0);
    add_cmd(mlte_pkg::CMD_READ, 1, 0, 32'h0, 1'b0);
    add_cmd(mlte_pkg::CMD_APPEND, 1, 0, 32'h8000_0000, 1'b0);
    add_cmd(mlte_pkg::CMD_APPEND, 1, 0, 32'h7FFF_FFFF, 1'b0);
    add_cmd(mlte_pkg::CMD_APPEND, 1, 0, 32'h0, 1'b0);
    add_cmd(mlte_pkg::CMD_DELETE, 1, 0, 32'h0, 1'b0);
    add_cmd(mlte_pkg::CMD_RESIZE, 1, -2, 32'h0, 1'b0);
    add_cmd(mlte_pkg::CMD_RESIZE, 1, -1, 32'h0, 1'b0);
    add_cmd(mlte_pkg::CMD_READ, 1, 0, 32'h0, 1'b0);
    add_cmd(mlte_pkg::CMD_RESIZE, 1, LIST_CAP - 1, 32'h0, 1'b0);
    add_cmd(mlte_pkg::CMD_RESIZE, 1, 1, 32'h0, 1'b0);
    add_cmd(mlte_pkg::CMD_CREATE, SLOT_COUNT, LIST_CAP, 32'h0, 1'b0);
    add_cmd(CMD_SPARE_A, 1, 3, 32'hFFFF_FFFF, 1'b0);
    add_cmd(CMD_SPARE_B, SLOT_COUNT, -3, 32'h1234_5678, 1'b0);
    add_cmd(mlte_pkg::CMD_DELETE, 1, 0, 32'h8000_0000, 1'b0);

    // Random: mostly create/append/delete/read runs on one slot, some noise.
    directed  = counted_cmds;
    first_seq = 1'b1;
    while (counted_cmds < directed + RANDOM_TARGET) begin
      roll = $urandom_range(0, 99);
      if (first_seq || roll >= 96) begin
        // Push a list past its capacity, stream it, then carve it down.
        s = first_seq ? SLOT_COUNT : $urandom_range(1, SLOT_COUNT);
        for (int i = 0; i <= LIST_CAP; i++)
          add_cmd(mlte_pkg::CMD_APPEND, s, 0, pick_value(), first_seq && i == 0);
        add_cmd(mlte_pkg::CMD_READ, s, 0, 32'h0, 1'b0);
        add_cmd(mlte_pkg::CMD_DELETE, s, 0, pick_value(), 1'b0);
        add_cmd(mlte_pkg::CMD_DELETE, s, 0, pick_value(), 1'b0);
        add_cmd(mlte_pkg::CMD_RESIZE, s, -int'($urandom_range(1, LIST_CAP)), 32'h0, 1'b0);
        add_cmd(mlte_pkg::CMD_READ, s, 0, 32'h0, 1'b0);
        first_seq = 1'b0;
      end else if (roll < 8) begin
        add_cmd(3'($urandom_range(0, 7)), $urandom_range(0, 15), $urandom_range(0, 255),
                $urandom(), 1'b0);
      end else begin
        s = $urandom_range(1, SLOT_COUNT);
        if (roll < 12) begin
          case ($urandom_range(0, 2))
            0:       size = 0;
            1:       size = -int'($urandom_range(1, 128));
            default: size = $urandom_range(LIST_CAP + 1, 127);
          endcase
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: size = $urandom_range(1, 8);
            6, 7, 8:          size = $urandom_range(9, LIST_CAP);
            default:          size = LIST_CAP;
          endcase
        end
        add_cmd(mlte_pkg::CMD_CREATE, s, size, pick_value(), $urandom_range(0, 14) == 0);
        repeat ($urandom_range(0, 10)) add_cmd(mlte_pkg::CMD_APPEND, s, 0, pick_value(), 1'b0);
        repeat ($urandom_range(0, 3)) add_cmd(mlte_pkg::CMD_DELETE, s, 0, pick_value(), 1'b0);
        if ($urandom_range(0, 3) == 0) add_cmd(mlte_pkg::CMD_REMOVE, s, 0, pick_value(), 1'b0);
        if ($urandom_range(0, 3) == 0)
          add_cmd(mlte_pkg::CMD_RESIZE, s, int'($urandom_range(0, 16)) - 8, pick_value(), 1'b0);
        if ($urandom_range(0, 3) == 0) add_cmd(mlte_pkg::CMD_APPEND, s, 0, pick_value(), 1'b0);
        if ($urandom_range(0, 4) != 0) add_cmd(mlte_pkg::CMD_READ, s, 0, pick_value(), 1'b0);
      end
    end
    cmds_total = command_queue.size();
  endtask

  // Driver: present one transaction at a time, hold it while busy, idle in bursts.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    pending_cmd_t item;
    bit launch;
    if (!rst_ni) begin
      start      <= 1'b0;
      req_i      <= '0;
      gap_left   = 0;
      burst_left = 0;
    end else if (!(start && busy)) begin
      // Either start was low or the transaction was taken at this edge.
      launch = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (command_queue.size() != 0) begin
        // A drain point holds off while start is high or results are awaited, so that drained has seen the last push.
        launch = !(command_queue[0].drain_first && (start || !drained));
      end
      if (launch) begin
        item = command_queue.pop_front();
        req_i <= item.req;
        if (burst_left == 0) burst_left = $urandom_range(1, 30);
        burst_left--;
        if (burst_left == 0)
          gap_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      end
      start <= launch;
    end
  end

  // Monitor: predict on every accepted transaction, check every result, watch for a hang.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drained <= 1'b1;
    end else begin
      // Predict first so a result is always checked against a complete queue.
      if (start && !busy) begin
        apply_list_command(req_i);
        cmds_accepted++;
      end
      if (res_valid_o) begin
        check_result(res_o);
        results_seen++;
      end
      drained <= (awaited_results.size() == 0);
      if ((start && !busy) || res_valid_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] no transaction for %0d cycles, giving up", $time, QUIET_LIMIT);
        $display("multi_list_table_engine_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin : sequencer
    int codes_hit;
    build_stimulus();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every transaction to be taken and answered, then let the block settle.
    while (cmds_accepted != cmds_total || awaited_results.size() != 0) @(posedge clk_i);
    repeat (END_SETTLE) @(posedge clk_i);
    if (awaited_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", awaited_results.size()));

    codes_hit = 0;
    foreach (status_tally[i]) if (status_tally[i] != 0) codes_hit++;
    $display("covered: %0d transactions (%0d spare codes), %0d results checked",
             cmds_accepted, spare_cmds, results_seen);
    $display("covered: %0d of %0d status codes, %0d read-all streams up to %0d entries",
             codes_hit, STATUS_CODES, reads_streamed, longest_read);
    if (error_count == 0) begin
      $display("multi_list_table_engine_unit regression: pass");
    end else begin
      $display("multi_list_table_engine_unit regression: fail");
    end
    $finish;
  end

endmodule
